FILE: rtl/dhcm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the decimated convolution monitor.
// Used by every module in rtl except dhcm_ram; depends on nothing.
package dhcm_pkg;

    localparam int CHANNELS    = 4;
    localparam int MAX_KERNEL  = 8192;
    localparam int MAX_INTERIM = 64;

    localparam int KA_W   = $clog2(MAX_KERNEL);
    localparam int IA_W   = $clog2(MAX_INTERIM);
    localparam int IC_W   = 7;
    localparam int KL_W   = 14;
    localparam int PER_W  = 16;
    localparam int DW     = 32;
    localparam int STEP_W = 32;
    localparam int CI_W   = 13;

    localparam int DIV_W  = 40;
    localparam int DVS_W  = 16;
    localparam int DIV_CW = $clog2(DIV_W);

    localparam int SUM_W   = DW + IA_W;
    localparam int PROD_W  = 2 * DW;
    localparam int ACC_W   = PROD_W + KA_W + 1;
    localparam int FRAC_SH = 30;
    localparam int DOT_W   = ACC_W - FRAC_SH;
    localparam int UNITY   = 65536;

    localparam int S_STEP_LO = 0;
    localparam int S_SMP_LO  = S_STEP_LO + STEP_W;
    localparam int S_CI_LO   = S_SMP_LO + CHANNELS * DW;
    localparam int S_CV_LO   = S_CI_LO + CI_W;
    localparam int S_BITS    = S_CV_LO + DW;
    localparam int S_TDATA_W = ((S_BITS + 7) / 8) * 8;
    localparam int M_BITS    = STEP_W + CHANNELS * DW;
    localparam int M_TDATA_W = ((M_BITS + 7) / 8) * 8;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_LOAD   = 1'b1;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_INTERIM = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KLEN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VMODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VSCALE  = 3'd4;

    localparam logic [IC_W-1:0]  RST_INTERIM = 7'd40;
    localparam logic [KL_W-1:0]  RST_KLEN    = 14'd5000;
    localparam logic [PER_W-1:0] RST_PERIOD  = 16'd20000;
    localparam logic             RST_VMODE   = 1'b1;
    localparam logic [DW-1:0]    RST_VSCALE  = 32'd7340;

    typedef struct packed {
        logic            iw_en;
        logic [IA_W-1:0] iw_addr;
        logic [IA_W-1:0] ir_addr;
        logic            sum_clr;
        logic            sum_acc;
        logic            sum_use;
        logic            mean_start;
        logic [IC_W-1:0] ic;
        logic            st_we;
        logic            st_zero;
        logic [KA_W-1:0] st_waddr;
        logic [KA_W-1:0] st_raddr;
        logic            dot_clr;
        logic            mul_v;
        logic            acc_v;
        logic            v_mag;
        logic            v_lo;
        logic            v_hi;
        logic            v_fin;
        logic            vmode;
        logic [DW-1:0]   scale;
    } lane_ctl_t;

    typedef struct packed {
        logic mean_done;
    } lane_stat_t;

endpackage

FILE: rtl/dhcm_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module dhcm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/dhcm_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on dhcm_pkg.
module dhcm_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [dhcm_pkg::DIV_W-1:0] dividend,
    input  logic [dhcm_pkg::DVS_W-1:0] divisor,
    output logic                       done,
    output logic [dhcm_pkg::DIV_W-1:0] quotient,
    output logic [dhcm_pkg::DVS_W-1:0] remainder
);

    logic [dhcm_pkg::DIV_W-1:0]  quo_reg;
    logic [dhcm_pkg::DVS_W-1:0]  rem_reg;
    logic [dhcm_pkg::DVS_W-1:0]  dvs_reg;
    logic [dhcm_pkg::DIV_CW-1:0] cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [dhcm_pkg::DVS_W:0]    shifted;
    logic [dhcm_pkg::DVS_W:0]    diff;
    logic                        ge;

    always_comb begin
        shifted = {rem_reg, quo_reg[dhcm_pkg::DIV_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        ge      = (shifted >= {1'b0, dvs_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
            cnt_reg <= dhcm_pkg::DIV_CW'(dhcm_pkg::DIV_W - 1);
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[dhcm_pkg::DIV_W-2:0], ge};
            rem_reg <= ge ? diff[dhcm_pkg::DVS_W-1:0] : shifted[dhcm_pkg::DVS_W-1:0];
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: rtl/dhcm_lane.sv
`timescale 1ns / 1ps
// One channel lane: interim ring, stock ring, mean divider, MAC and output scaling.
// Depends on dhcm_pkg, dhcm_ram and dhcm_div.
module dhcm_lane (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  dhcm_pkg::lane_ctl_t     ctl,
    input  logic [dhcm_pkg::DW-1:0] sample,
    input  logic [dhcm_pkg::DW-1:0] kern,
    output dhcm_pkg::lane_stat_t    stat,
    output logic [dhcm_pkg::DW-1:0] result
);

    localparam int DW    = dhcm_pkg::DW;
    localparam int SUM_W = dhcm_pkg::SUM_W;
    localparam int ACC_W = dhcm_pkg::ACC_W;
    localparam int DOT_W = dhcm_pkg::DOT_W;
    localparam int PW    = dhcm_pkg::PROD_W;

    logic [DW-1:0]    ir_data;
    logic [DW-1:0]    st_data;
    logic [DW-1:0]    st_wdata;
    logic             div_done;
    logic [dhcm_pkg::DIV_W-1:0] div_quo;
    logic [dhcm_pkg::DVS_W-1:0] div_rem;

    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_mag;
    logic             sneg_reg;
    logic [DW-1:0]    mean_reg;
    logic [PW-1:0]    prod_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [DOT_W-1:0] mag_reg;
    logic             vneg_reg;
    logic [DW-1:0]    smag_reg;
    logic [PW-1:0]    plo_reg;
    logic [DOT_W-1:0] phi_reg;
    logic [DW-1:0]    res_reg;

    logic [DOT_W-1:0] dot;
    logic [DOT_W:0]   dext;
    logic [DOT_W:0]   dabs;
    logic [PW:0]      rsum;
    logic [DW-1:0]    vres;
    logic [DW-1:0]    pres;
    logic             dot_fits;

    dhcm_ram #(.WIDTH(DW), .DEPTH(dhcm_pkg::MAX_INTERIM)) u_interim (
        .aclk  (aclk),
        .we    (ctl.iw_en),
        .waddr (ctl.iw_addr),
        .wdata (sample),
        .raddr (ctl.ir_addr),
        .rdata (ir_data)
    );

    assign st_wdata = ctl.st_zero ? '0 : mean_reg;

    dhcm_ram #(.WIDTH(DW), .DEPTH(dhcm_pkg::MAX_KERNEL)) u_stock (
        .aclk  (aclk),
        .we    (ctl.st_we),
        .waddr (ctl.st_waddr),
        .wdata (st_wdata),
        .raddr (ctl.st_raddr),
        .rdata (st_data)
    );

    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : sum_reg;

    dhcm_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (ctl.mean_start),
        .dividend  (dhcm_pkg::DIV_W'(sum_mag)),
        .divisor   (dhcm_pkg::DVS_W'(ctl.ic)),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb begin
        dot      = acc_reg[ACC_W-1:dhcm_pkg::FRAC_SH];
        dext     = {dot[DOT_W-1], dot} - (DOT_W+1)'(dhcm_pkg::UNITY);
        dabs     = dext[DOT_W] ? (DOT_W+1)'(-dext) : dext;
        rsum     = {1'b0, phi_reg, 16'b0} + (PW+1)'(plo_reg[PW-1:16]);
        dot_fits = (dot[DOT_W-1:DW-1] == '0) || (dot[DOT_W-1:DW-1] == '1);
        if (vneg_reg) begin
            vres = (rsum >= (PW+1)'(33'h080000000)) ? 32'h80000000 : 32'(32'd0 - rsum[DW-1:0]);
        end else begin
            vres = (rsum > (PW+1)'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : rsum[DW-1:0];
        end
        if (dot_fits) begin
            pres = dot[DW-1:0];
        end else begin
            pres = dot[DOT_W-1] ? 32'h80000000 : 32'h7FFFFFFF;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.sum_clr) begin
            sum_reg <= '0;
        end else if (ctl.sum_acc) begin
            sum_reg <= sum_reg + (ctl.sum_use ? SUM_W'($signed(ir_data)) : '0);
        end
        if (ctl.mean_start) begin
            sneg_reg <= sum_reg[SUM_W-1];
        end
        if (div_done) begin
            mean_reg <= sneg_reg ? DW'(-div_quo[DW-1:0]) : div_quo[DW-1:0];
        end
        if (ctl.mul_v) begin
            prod_reg <= PW'($signed(st_data) * $signed(kern));
        end
        if (ctl.dot_clr) begin
            acc_reg <= '0;
        end else if (ctl.acc_v) begin
            acc_reg <= acc_reg + ACC_W'($signed(prod_reg));
        end
        if (ctl.v_mag) begin
            mag_reg  <= dabs[DOT_W-1:0];
            vneg_reg <= dext[DOT_W] ^ ctl.scale[DW-1];
            smag_reg <= ctl.scale[DW-1] ? DW'(-ctl.scale) : ctl.scale;
        end
        if (ctl.v_lo) begin
            plo_reg <= PW'(mag_reg[DW-1:0] * smag_reg);
        end
        if (ctl.v_hi) begin
            phi_reg <= DOT_W'(mag_reg[DOT_W-1:DW] * smag_reg);
        end
        if (ctl.v_fin) begin
            res_reg <= ctl.vmode ? vres : pres;
        end
    end

    assign stat.mean_done = div_done;
    assign result         = res_reg;

endmodule

FILE: rtl/decimated_hrf_convolution_monitor_top.sv
`timescale 1ns / 1ps
// Top level of the decimated convolution monitor: control sequencer, kernel store and lanes.
// Depends on dhcm_pkg, dhcm_ram, dhcm_div and dhcm_lane.
//
// Input transactions arrive on the s_ stream. tuser bit 0 selects the kind: a sample
// transaction carries a step number and one value per channel, a load transaction writes
// one kernel tap. Results leave on the m_ stream, one per sample whose step is a multiple
// of output_period. Registers must be written over the cfg_ channel only while the block
// is idle; the block itself does not enforce this. A sample transaction runs three passes
// of the shared restoring divider (slot, decimated index, period). A sample that closes
// an averaging window adds a sweep of the interim ring and a mean division in every lane.
// An emitting sample adds a pass in which the lanes run one multiply-accumulate per stock
// entry, then a split multiply and saturation stage.
// After reset all 8192 entries of the stock rings are cleared, one entry per cycle; no
// input transaction is accepted meanwhile. The result sits in an output register; a
// stalled receiver holds the block only when a newer result is ready to be written there.
module decimated_hrf_convolution_monitor_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // step, sample_0, sample_1, sample_2, sample_3, coef_index, coef_value, zero pad
    input  logic [dhcm_pkg::S_TDATA_W-1:0]      s_tdata,
    // func
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_step, bold_0, bold_1, bold_2, bold_3
    output logic [dhcm_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dhcm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dhcm_pkg::DW-1:0]             cfg_data
);

    localparam int CH   = dhcm_pkg::CHANNELS;
    localparam int DW   = dhcm_pkg::DW;
    localparam int KA_W = dhcm_pkg::KA_W;
    localparam int IA_W = dhcm_pkg::IA_W;
    localparam int IC_W = dhcm_pkg::IC_W;
    localparam int KL_W = dhcm_pkg::KL_W;

    localparam logic [4:0] ST_CLEAR = 5'd0;
    localparam logic [4:0] ST_IDLE  = 5'd1;
    localparam logic [4:0] ST_DIV1  = 5'd2;
    localparam logic [4:0] ST_DIV2  = 5'd3;
    localparam logic [4:0] ST_DIV3  = 5'd4;
    localparam logic [4:0] ST_IWR   = 5'd5;
    localparam logic [4:0] ST_SUM   = 5'd6;
    localparam logic [4:0] ST_MEAN  = 5'd7;
    localparam logic [4:0] ST_SWR   = 5'd8;
    localparam logic [4:0] ST_CHK   = 5'd9;
    localparam logic [4:0] ST_DOT   = 5'd10;
    localparam logic [4:0] ST_VMAG  = 5'd11;
    localparam logic [4:0] ST_VLO   = 5'd12;
    localparam logic [4:0] ST_VHI   = 5'd13;
    localparam logic [4:0] ST_VFIN  = 5'd14;
    localparam logic [4:0] ST_OUT   = 5'd15;

    logic [4:0]                   state_reg, state_next;
    logic [IC_W-1:0]              cfg_ic_reg;
    logic [KL_W-1:0]              cfg_kl_reg;
    logic [dhcm_pkg::PER_W-1:0]   cfg_per_reg;
    logic                         cfg_vm_reg;
    logic [DW-1:0]                cfg_scale_reg;

    logic [KA_W-1:0]              clr_reg;
    logic [dhcm_pkg::MAX_INTERIM-1:0] ival_reg;
    logic [dhcm_pkg::STEP_W-1:0]  step_reg;
    logic [DW-1:0]                smp_reg [CH];
    logic [IA_W-1:0]              r1_reg;
    logic [KA_W-1:0]              qm_reg;
    logic                         rpz_reg;
    logic [IC_W-1:0]              k_reg;
    logic                         svld_reg;
    logic                         iv_reg;
    logic [KL_W-1:0]              i_reg;
    logic [KA_W-1:0]              tap_reg;
    logic                         v1_reg;
    logic                         v2_reg;
    logic                         m_tvalid_reg;
    logic [dhcm_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic [IC_W-1:0]              ic_eff;
    logic [KL_W-1:0]              len_eff;
    logic [dhcm_pkg::PER_W-1:0]   per_eff;
    logic                         s_acc;
    logic                         k_we;
    logic [DW-1:0]                k_rdata;
    logic                         div_start;
    logic [dhcm_pkg::DIV_W-1:0]   div_dvd;
    logic [dhcm_pkg::DVS_W-1:0]   div_dvs;
    logic                         div_done;
    logic [dhcm_pkg::DIV_W-1:0]   div_quo;
    logic [dhcm_pkg::DVS_W-1:0]   div_rem;
    logic [IA_W-1:0]              islot;
    logic [KA_W-1:0]              sslot;
    logic [KL_W:0]                t0w;
    logic [KA_W-1:0]              t0;
    logic [KL_W:0]                tap_inc;
    logic                         sum_issue;
    logic                         dot_issue;
    logic                         out_free;
    logic [dhcm_pkg::M_TDATA_W-1:0] out_word;
    dhcm_pkg::lane_ctl_t          ctl;
    dhcm_pkg::lane_stat_t         stat [CH];
    logic [DW-1:0]                res [CH];

    assign ic_eff  = (cfg_ic_reg == '0) ? IC_W'(1) :
                     (cfg_ic_reg > IC_W'(dhcm_pkg::MAX_INTERIM)) ?
                     IC_W'(dhcm_pkg::MAX_INTERIM) : cfg_ic_reg;
    assign len_eff = (cfg_kl_reg == '0) ? KL_W'(1) :
                     (cfg_kl_reg > KL_W'(dhcm_pkg::MAX_KERNEL)) ?
                     KL_W'(dhcm_pkg::MAX_KERNEL) : cfg_kl_reg;
    assign per_eff = (cfg_per_reg == '0) ? dhcm_pkg::PER_W'(1) : cfg_per_reg;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign k_we      = s_acc && (s_tuser[0] == dhcm_pkg::FUNC_LOAD);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign islot = (r1_reg == '0) ? IA_W'(ic_eff - 1'b1) : r1_reg - 1'b1;
    assign sslot = (qm_reg == '0) ? KA_W'(len_eff - 1'b1) : qm_reg - 1'b1;
    assign t0w   = (KL_W+1)'(len_eff) + (KL_W+1)'(1) - (KL_W+1)'(qm_reg);
    assign t0    = (qm_reg == '0) ? ((len_eff == KL_W'(1)) ? '0 : KA_W'(1)) :
                   ((t0w == (KL_W+1)'(len_eff)) ? '0 : KA_W'(t0w));
    assign tap_inc   = (KL_W+1)'(tap_reg) + 1'b1;
    assign sum_issue = (state_reg == ST_SUM) && (k_reg < ic_eff);
    assign dot_issue = (state_reg == ST_DOT) && (i_reg < len_eff);

    dhcm_ram #(.WIDTH(DW), .DEPTH(dhcm_pkg::MAX_KERNEL)) u_kernel (
        .aclk  (aclk),
        .we    (k_we),
        .waddr (s_tdata[dhcm_pkg::S_CI_LO +: KA_W]),
        .wdata (s_tdata[dhcm_pkg::S_CV_LO +: DW]),
        .raddr (tap_reg),
        .rdata (k_rdata)
    );

    dhcm_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        div_dvd    = '0;
        div_dvs    = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == KA_W'(dhcm_pkg::MAX_KERNEL - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_acc && s_tuser[0] == dhcm_pkg::FUNC_SAMPLE) begin
                    div_start  = 1'b1;
                    div_dvd    = dhcm_pkg::DIV_W'(s_tdata[dhcm_pkg::S_STEP_LO +: 32]);
                    div_dvs    = dhcm_pkg::DVS_W'(ic_eff);
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1: begin
                if (div_done) begin
                    div_start  = 1'b1;
                    div_dvd    = div_quo;
                    div_dvs    = dhcm_pkg::DVS_W'(len_eff);
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2: begin
                if (div_done) begin
                    div_start  = 1'b1;
                    div_dvd    = dhcm_pkg::DIV_W'(step_reg);
                    div_dvs    = per_eff;
                    state_next = ST_DIV3;
                end
            end
            ST_DIV3: begin
                if (div_done) begin
                    state_next = ST_IWR;
                end
            end
            ST_IWR: begin
                state_next = (r1_reg == '0) ? ST_SUM : ST_CHK;
            end
            ST_SUM: begin
                if (k_reg == ic_eff && !svld_reg) begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN: begin
                if (stat[0].mean_done) begin
                    state_next = ST_SWR;
                end
            end
            ST_SWR:  state_next = ST_CHK;
            ST_CHK:  state_next = rpz_reg ? ST_DOT : ST_IDLE;
            ST_DOT: begin
                if (i_reg == len_eff && !v1_reg && !v2_reg) begin
                    state_next = ST_VMAG;
                end
            end
            ST_VMAG: state_next = ST_VLO;
            ST_VLO:  state_next = ST_VHI;
            ST_VHI:  state_next = ST_VFIN;
            ST_VFIN: state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctl.iw_en      = (state_reg == ST_IWR);
        ctl.iw_addr    = islot;
        ctl.ir_addr    = k_reg[IA_W-1:0];
        ctl.sum_clr    = (state_reg == ST_IWR);
        ctl.sum_acc    = svld_reg;
        ctl.sum_use    = iv_reg;
        ctl.mean_start = (state_reg == ST_SUM) && (state_next == ST_MEAN);
        ctl.ic         = ic_eff;
        ctl.st_we      = (state_reg == ST_CLEAR) || (state_reg == ST_SWR);
        ctl.st_zero    = (state_reg == ST_CLEAR);
        ctl.st_waddr   = (state_reg == ST_CLEAR) ? clr_reg : sslot;
        ctl.st_raddr   = i_reg[KA_W-1:0];
        ctl.dot_clr    = (state_reg == ST_CHK);
        ctl.mul_v      = v1_reg;
        ctl.acc_v      = v2_reg;
        ctl.v_mag      = (state_reg == ST_VMAG);
        ctl.v_lo       = (state_reg == ST_VLO);
        ctl.v_hi       = (state_reg == ST_VHI);
        ctl.v_fin      = (state_reg == ST_VFIN);
        ctl.vmode      = cfg_vm_reg;
        ctl.scale      = cfg_scale_reg;
    end

    for (genvar c = 0; c < CH; c++) begin : g_lane
        dhcm_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .sample  (smp_reg[c]),
            .kern    (k_rdata),
            .stat    (stat[c]),
            .result  (res[c])
        );
    end

    always_comb begin
        out_word = '0;
        out_word[0 +: dhcm_pkg::STEP_W] = step_reg;
        for (int c = 0; c < CH; c++) begin
            out_word[dhcm_pkg::STEP_W + c * DW +: DW] = res[c];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            ival_reg      <= '0;
            svld_reg      <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            cfg_ic_reg    <= dhcm_pkg::RST_INTERIM;
            cfg_kl_reg    <= dhcm_pkg::RST_KLEN;
            cfg_per_reg   <= dhcm_pkg::RST_PERIOD;
            cfg_vm_reg    <= dhcm_pkg::RST_VMODE;
            cfg_scale_reg <= dhcm_pkg::RST_VSCALE;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == ST_IWR) begin
                ival_reg[islot] <= 1'b1;
            end
            svld_reg <= sum_issue;
            v1_reg   <= dot_issue;
            v2_reg   <= v1_reg;
            if (state_reg == ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    dhcm_pkg::REG_INTERIM: cfg_ic_reg    <= cfg_data[IC_W-1:0];
                    dhcm_pkg::REG_KLEN:    cfg_kl_reg    <= cfg_data[KL_W-1:0];
                    dhcm_pkg::REG_PERIOD:  cfg_per_reg   <= cfg_data[dhcm_pkg::PER_W-1:0];
                    dhcm_pkg::REG_VMODE:   cfg_vm_reg    <= cfg_data[0];
                    dhcm_pkg::REG_VSCALE:  cfg_scale_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && s_tuser[0] == dhcm_pkg::FUNC_SAMPLE) begin
            step_reg <= s_tdata[dhcm_pkg::S_STEP_LO +: dhcm_pkg::STEP_W];
            for (int c = 0; c < CH; c++) begin
                smp_reg[c] <= s_tdata[dhcm_pkg::S_SMP_LO + c * DW +: DW];
            end
        end
        if (state_reg == ST_DIV1 && div_done) begin
            r1_reg <= div_rem[IA_W-1:0];
        end
        if (state_reg == ST_DIV2 && div_done) begin
            qm_reg <= div_rem[KA_W-1:0];
        end
        if (state_reg == ST_DIV3 && div_done) begin
            rpz_reg <= (div_rem == '0);
        end
        if (state_reg == ST_IWR) begin
            k_reg <= '0;
        end else if (sum_issue) begin
            k_reg <= k_reg + 1'b1;
        end
        iv_reg <= ival_reg[k_reg[IA_W-1:0]];
        if (state_reg == ST_CHK) begin
            i_reg   <= '0;
            tap_reg <= t0;
        end else if (dot_issue) begin
            i_reg   <= i_reg + 1'b1;
            tap_reg <= (tap_inc == (KL_W+1)'(len_eff)) ? '0 : KA_W'(tap_inc);
        end
        if (state_reg == ST_OUT && out_free) begin
            m_tdata_reg <= out_word;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("input accepted during stock clear");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV1 || state_reg == ST_DIV2 || state_reg == ST_DIV3))
        else $error("divider finished outside a division state");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && m_tvalid_reg && !m_tready) |=>
        (state_reg == ST_OUT && m_tvalid_reg))
        else $error("pending result overwritten");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for decimated_hrf_convolution_monitor_top: a queue-fed stream
// driver, a result monitor and a behavioral predictor of the averaging and FIR stages.
// Depends on dhcm_pkg and the RTL top level only.
module tb_top;
    import dhcm_pkg::*;

    localparam int LIMIT = 4000000;
    localparam int TAPS  = 256;

    typedef struct packed {
        logic                       func;
        logic [31:0]                step;
        logic [CHANNELS-1:0][31:0]  smp;
        logic [12:0]                cidx;
        logic [31:0]                cval;
    } stim_t;

    typedef struct packed {
        logic [31:0]                step;
        logic [CHANNELS-1:0][31:0]  bold;
    } bold_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [S_TDATA_W-1:0]     s_tdata = '0;
    logic [0:0]               s_tuser = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [M_TDATA_W-1:0]     m_tdata;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [DW-1:0]            cfg_data = '0;

    stim_t stim_queue[$];
    bold_t bold_expected[$];

    logic [IC_W-1:0]    cur_ic;
    logic [KL_W-1:0]    cur_kl;
    logic [PER_W-1:0]   cur_per;
    logic               cur_vm;
    logic signed [31:0] cur_vs;

    logic signed [31:0] interim_m [MAX_INTERIM][CHANNELS];
    logic signed [31:0] stock_m [MAX_KERNEL][CHANNELS];
    logic signed [31:0] kern_m [MAX_KERNEL];

    int errors = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_cfg = 0;
    int cycles = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_mode = 0;
    int stall_cnt = 0;

    decimated_hrf_convolution_monitor_top dut (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int eff_ic();
        if (cur_ic == 0) return 1;
        if (cur_ic > MAX_INTERIM) return MAX_INTERIM;
        return int'(cur_ic);
    endfunction

    function automatic int eff_kl();
        if (cur_kl == 0) return 1;
        if (cur_kl > MAX_KERNEL) return MAX_KERNEL;
        return int'(cur_kl);
    endfunction

    function automatic logic [31:0] clamp32(input logic signed [127:0] v);
        if (v > 128'sd2147483647) return 32'h7FFFFFFF;
        if (v < -128'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic void advance_monitor(input stim_t it);
        longint unsigned stp;
        int ic, kl, per, slot, qm, s, tap;
        longint sum;
        logic signed [79:0] acc;
        logic signed [127:0] d, p, q, scl;
        bold_t r;
        if (it.func == FUNC_LOAD) begin
            kern_m[it.cidx] = it.cval;
            return;
        end
        stp = it.step;
        ic = eff_ic();
        kl = eff_kl();
        per = (cur_per == 0) ? 1 : int'(cur_per);
        slot = int'((stp % ic + ic - 1) % ic);
        for (int c = 0; c < CHANNELS; c++) interim_m[slot][c] = it.smp[c];
        qm = int'((stp / ic) % kl);
        if (stp % ic == 0) begin
            s = (qm + kl - 1) % kl;
            for (int c = 0; c < CHANNELS; c++) begin
                sum = 0;
                for (int k = 0; k < ic; k++) sum += interim_m[k][c];
                sum = sum / longint'(ic);
                stock_m[s][c] = sum[31:0];
            end
        end
        if (stp % per != 0) return;
        r.step = it.step;
        scl = cur_vs;
        for (int c = 0; c < CHANNELS; c++) begin
            acc = 0;
            for (int i = 0; i < kl; i++) begin
                tap = (i + 1 + kl - qm) % kl;
                acc += longint'(stock_m[i][c]) * longint'(kern_m[tap]);
            end
            d = acc >>> 30;
            if (cur_vm) begin
                p = (d - 128'sd65536) * scl;
                q = (p < 0) ? -((-p) >>> 16) : (p >>> 16);
                r.bold[c] = clamp32(q);
            end else begin
                r.bold[c] = clamp32(d);
            end
        end
        bold_expected.push_back(r);
    endfunction

    // Stream driver: bursts of random length separated by random gaps.
    always @(posedge aclk) begin
        logic holding;
        holding = s_tvalid && !s_tready;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                advance_monitor(stim_queue.pop_front());
                n_accepted++;
            end
            if (holding) begin
            end else if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (stim_queue.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {3'b000, stim_queue[0].cval, stim_queue[0].cidx,
                             stim_queue[0].smp, stim_queue[0].step};
                s_tuser  <= stim_queue[0].func;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                end else begin
                    burst_left--;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result side: the m_tready stall pattern is redrawn at random, periodically.
    always @(posedge aclk) begin
        bold_t exp_r;
        cycles++;
        if (cycles >= LIMIT) begin
            $display("decimated_hrf_convolution_monitor_top test failed");
            $finish;
        end
        stall_cnt++;
        if (stall_cnt == 64) begin
            stall_cnt = 0;
            stall_mode = $urandom_range(0, 3);
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= $urandom_range(0, 1);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ($urandom_range(0, 15) == 0);
        endcase
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (bold_expected.size() == 0) begin
                $error("unexpected result transaction, out_step %h", m_tdata[31:0]);
                errors++;
            end else begin
                exp_r = bold_expected.pop_front();
                if (m_tdata[31:0] !== exp_r.step) begin
                    $error("out_step expected %h actual %h", exp_r.step, m_tdata[31:0]);
                    errors++;
                end
                for (int c = 0; c < CHANNELS; c++) begin
                    if (m_tdata[32 + 32*c +: 32] !== exp_r.bold[c]) begin
                        $error("bold_%0d expected %h actual %h", c, exp_r.bold[c],
                               m_tdata[32 + 32*c +: 32]);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        n_cfg++;
        case (idx)
            REG_INTERIM: cur_ic = data[IC_W-1:0];
            REG_KLEN:    cur_kl = data[KL_W-1:0];
            REG_PERIOD:  cur_per = data[PER_W-1:0];
            REG_VMODE:   cur_vm = data[0];
            REG_VSCALE:  cur_vs = data;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (stim_queue.size() != 0 || s_tvalid || bold_expected.size() != 0)
            @(posedge aclk);
        repeat (200 + eff_ic() + eff_kl() + 64) @(posedge aclk);
    endtask

    task automatic configure(input int ic, input int kl, input int per, input int vm,
                             input logic [31:0] vs);
        wait_idle();
        write_reg(REG_INTERIM, ($urandom << IC_W) | ic);
        write_reg(REG_KLEN, ($urandom << KL_W) | kl);
        write_reg(REG_PERIOD, ($urandom << PER_W) | per);
        write_reg(REG_VMODE, ($urandom << 1) | vm);
        write_reg(REG_VSCALE, vs);
    endtask

    function automatic logic [31:0] pick_value();
        int v;
        case ($urandom_range(0, 7))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2, 3, 4: begin
                v = int'($urandom_range(0, 262143)) - 131072;
                return v;
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_coef();
        int v;
        case ($urandom_range(0, 9))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom;
            default: begin
                v = int'($urandom_range(0, 32'h1FFFFFFF)) - 32'sh10000000;
                return v;
            end
        endcase
    endfunction

    function automatic logic [31:0] pick_scale();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'h00010000;
            3: return $urandom_range(0, 20000);
            default: return $urandom;
        endcase
    endfunction

    function automatic stim_t make_sample(input logic [31:0] step);
        stim_t it;
        it.func = FUNC_SAMPLE;
        it.step = step;
        for (int c = 0; c < CHANNELS; c++) it.smp[c] = pick_value();
        it.cidx = $urandom;
        it.cval = $urandom;
        return it;
    endfunction

    function automatic stim_t make_load(input int idx, input logic [31:0] val);
        stim_t it;
        it.func = FUNC_LOAD;
        it.step = $urandom;
        for (int c = 0; c < CHANNELS; c++) it.smp[c] = $urandom;
        it.cidx = idx;
        it.cval = val;
        return it;
    endfunction

    task automatic queue_run(input int n, input int load_pct);
        logic [31:0] nxt;
        case ($urandom_range(0, 2))
            0: nxt = 0;
            1: nxt = 32'hFFFFFFFF - $urandom_range(0, 40);
            default: nxt = $urandom;
        endcase
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < load_pct) begin
                stim_queue.push_back(make_load($urandom_range(0, MAX_KERNEL - 1), pick_coef()));
            end else begin
                if ($urandom_range(0, 24) == 0) nxt = $urandom;
                stim_queue.push_back(make_sample(nxt));
                nxt = nxt + 1;
            end
        end
    endtask

    initial begin
        stim_t it;
        cur_ic = RST_INTERIM;
        cur_kl = RST_KLEN;
        cur_per = RST_PERIOD;
        cur_vm = RST_VMODE;
        cur_vs = RST_VSCALE;
        for (int i = 0; i < MAX_INTERIM; i++)
            for (int c = 0; c < CHANNELS; c++) interim_m[i][c] = 0;
        for (int i = 0; i < MAX_KERNEL; i++)
            for (int c = 0; c < CHANNELS; c++) stock_m[i][c] = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Every tap that a result can read is written first.
        stim_queue.push_back(make_load(0, 32'h7FFFFFFF));
        stim_queue.push_back(make_load(1, 32'h80000000));
        for (int i = 2; i < TAPS; i++) stim_queue.push_back(make_load(i, pick_coef()));

        // Directed samples at the reset configuration; none of them emits.
        it = make_sample(1);
        it.smp = {CHANNELS{32'h7FFFFFFF}};
        stim_queue.push_back(it);
        it = make_sample(2);
        it.smp = {CHANNELS{32'h80000000}};
        stim_queue.push_back(it);
        stim_queue.push_back(make_sample(39));
        stim_queue.push_back(make_sample(40));
        stim_queue.push_back(make_sample(32'hFFFFFFFF));

        configure(1, 4, 1, 0, 32'h00010000);
        queue_run(60, 10);
        configure(0, 0, 0, 1, 32'h7FFFFFFF);
        queue_run(40, 10);
        configure(64, 16, 3, 1, 32'h80000000);
        queue_run(80, 10);
        configure(127, 16383, 65535, 0, pick_scale());
        for (int k = 1; k <= 6; k++) stim_queue.push_back(make_sample(32'(k * 32)));
        configure(2, TAPS, 1, 1, 32'h00001CAC);
        queue_run(4, 0);
        configure(64, 40, 65535, 1, pick_scale());
        queue_run(30, 0);
        stim_queue.push_back(make_sample(65535 * 64));
        wait_idle();
        for (int r = int'(REG_VSCALE) + 1; r < 2 ** CFG_IDX_W; r++)
            write_reg(CFG_IDX_W'(r), $urandom);

        for (int ph = 0; ph < 13; ph++) begin
            configure($urandom_range(1, 70), $urandom_range(1, 48), $urandom_range(1, 8),
                      $urandom_range(0, 1), pick_scale());
            queue_run(90, 10);
        end

        wait_idle();
        if (bold_expected.size() != 0) begin
            $error("%0d expected results never arrived", bold_expected.size());
            errors++;
        end
        $display("Covered %0d input transactions, %0d results and %0d register writes,",
                 n_accepted, n_results, n_cfg);
        $display("over register extremes, both output modes and step wraparound.");
        if (errors == 0) begin
            $display("decimated_hrf_convolution_monitor_top test passed");
        end else begin
            $display("decimated_hrf_convolution_monitor_top test failed");
        end
        $finish;
    end

endmodule
